// ===== src/q4_block_dequantizer_unit_macros.svh =====
// Assertion macros for the block dequantizer
`ifndef Q4_BLOCK_DEQUANTIZER_UNIT_MACROS_SVH
`define Q4_BLOCK_DEQUANTIZER_UNIT_MACROS_SVH
`ifndef SYNTH
`define Q4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define Q4_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define Q4_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define Q4_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/q4bd_pkg.sv =====
package q4bd_pkg;
    localparam int unsigned BlockValues = 32;
    localparam logic [3:0] NibbleBias = 4'd8;

    typedef struct packed {
        logic [15:0]  scale_half;
        logic [127:0] quant_bytes;
        logic [5:0]   value_count;
    } blk_t;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [4:0]  value_index;
        logic        last_value;
    } res_t;

    // exact binary32 of sign * k * half magnitude, k in 0..8
    function automatic logic [31:0] scaled_bits(input logic sign, input logic [3:0] k,
                                                input logic [4:0] hexp,
                                                input logic [9:0] hman);
        logic [10:0] m;
        logic [13:0] prod;
        logic [3:0]  p;
        logic [7:0]  fexp;
        logic [22:0] fman;
        logic [36:0] sh;
        m = (hexp == 5'd0) ? {1'b0, hman} : {1'b1, hman};
        prod = 14'(m) * 14'(k);
        p = 4'd0;
        for (int b = 1; b < 14; b++)
        begin
            if (prod[b])
            begin
                p = 4'(b);
            end
        end
        // exponent: p + e + 127, e = hexp-25 (normal) or -24 (subnormal)
        fexp = (hexp == 5'd0) ? 8'(8'd103 + 8'(p)) : 8'(8'(hexp) + 8'd102 + 8'(p));
        sh = {23'd0, prod} << (5'd23 - 5'(p));
        fman = sh[22:0];
        if (prod == 14'd0)
        begin
            scaled_bits = {sign, 31'd0};
        end
        else
        begin
            scaled_bits = {sign, fexp, fman};
        end
    endfunction
endpackage

// ===== src/q4bd_if.sv =====
interface q4bd_blk_if;
    import q4bd_pkg::*;
    logic         valid;
    logic         ready;
    logic [15:0]  scale_half;
    logic [63:0]  quant_bytes_lo;
    logic [63:0]  quant_bytes_hi;
    logic [5:0]   value_count;
    modport source (output valid, scale_half, quant_bytes_lo, quant_bytes_hi, value_count,
                    input ready);
    modport sink (input valid, scale_half, quant_bytes_lo, quant_bytes_hi, value_count,
                  output ready);
endinterface

interface q4bd_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic [4:0]  value_index;
    logic        last_value;
    modport source (output valid, value_bits, value_index, last_value, input ready);
    modport sink (input valid, value_bits, value_index, last_value, output ready);
endinterface

// ===== src/q4bd_cell.sv =====
module q4bd_cell
    import q4bd_pkg::*;
(
    input  logic       clk,
    input  logic       load,
    input  logic       shift,
    input  logic [3:0] load_nib,
    input  logic [3:0] prev_nib,
    output logic [3:0] nib
);
    logic [3:0] nib_reg;
    logic [3:0] nib_next;

    always_comb
    begin
        nib_next = nib_reg;
        if (load)
        begin
            nib_next = load_nib;
        end
        else if (shift)
        begin
            nib_next = prev_nib;
        end
    end

    always_ff @(posedge clk)
    begin
        nib_reg <= nib_next;
    end

    assign nib = nib_reg;
endmodule

// ===== src/q4_block_dequantizer_unit.sv =====
// Block dequantizer for 4-bit quantized weights.
// Input channel blk: one block per transaction (binary16 scale, 16 packed
// bytes, value_count). Output channel res: one binary32 value per
// transaction with its index and a last flag on the final one.
// A block loads into a row of 32 nibble cells; each output transaction
// shifts the row by one cell and the head cell feeds the scale multiplier.
// After a block is accepted, the busy flag is registered and the head cell
// then feeds the result register. Each block gives value_count values
// (1..32; counts above 32 give 32, zero gives none); the next block is
// accepted in the cycle the last value of the current one is taken, so
// blocks follow with no gap. A pending result holds, and the row stalls, while res.ready is low.
// Reset clears the busy and valid flags; the row contents are not reset.
// A NaN or infinite scale gives +0 for every value.
`include "q4_block_dequantizer_unit_macros.svh"
module q4_block_dequantizer_unit
    import q4bd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    q4bd_blk_if.sink   blk,
    q4bd_res_if.source res
);
    logic [3:0]  nib [BlockValues];
    logic        busy_reg, busy_next;
    logic [5:0]  left_reg, left_next;
    logic [4:0]  idx_reg, idx_next;
    logic [15:0] scale_reg, scale_next;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;
    logic        take, load, shift;
    logic [127:0] qb;
    logic [5:0]  cnt;
    logic        special;

    assign qb = {blk.quant_bytes_hi, blk.quant_bytes_lo};
    assign cnt = (blk.value_count > 6'd32) ? 6'd32 : blk.value_count;
    // produce a value when the output slot is free or being drained
    assign take = busy_reg && (!out_valid_reg || res.ready);
    assign blk.ready = !busy_reg || (take && left_reg == 6'd1);
    assign load = blk.valid && blk.ready && cnt != 6'd0;
    assign shift = take;
    assign special = scale_reg[14:10] == 5'h1F;

    for (genvar g = 0; g < BlockValues; g++)
    begin : g_row
        logic [3:0] prev;
        if (g == BlockValues - 1)
        begin : g_tail
            assign prev = 4'd0;
        end
        else
        begin : g_mid
            assign prev = nib[g + 1];
        end
        q4bd_cell u_cell (
            .clk(clk), .load(load), .shift(shift),
            .load_nib(qb[4*g +: 4]), .prev_nib(prev), .nib(nib[g])
        );
    end

    always_comb
    begin
        logic       neg;
        logic [3:0] k;
        busy_next = busy_reg;
        left_next = left_reg;
        idx_next = idx_reg;
        scale_next = scale_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        neg = nib[0] < NibbleBias;
        k = neg ? 4'(NibbleBias - nib[0]) : 4'(nib[0] - NibbleBias);
        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            out_next.value_bits = special ? 32'd0 :
                scaled_bits(scale_reg[15] ^ neg, k, scale_reg[14:10], scale_reg[9:0]);
            out_next.value_index = idx_reg;
            out_next.last_value = left_reg == 6'd1;
            idx_next = idx_reg + 5'd1;
            left_next = left_reg - 6'd1;
            if (left_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            left_next = cnt;
            idx_next = 5'd0;
            scale_next = blk.scale_half;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg <= 6'd0;
            idx_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            out_valid_reg <= out_valid_next;
            left_reg <= left_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
        out_reg <= out_next;
    end

    assign res.valid = out_valid_reg;
    assign res.value_bits = out_reg.value_bits;
    assign res.value_index = out_reg.value_index;
    assign res.last_value = out_reg.last_value;

    `Q4_ASSERT_IMP(a_busy_left, clk, rst_n, busy_reg, left_reg != 6'd0 && left_reg <= 6'd32)
    `Q4_ASSERT_NXT(a_load_busy, clk, rst_n, load, busy_reg && idx_reg == 5'd0)
    `Q4_ASSERT_IMP(a_no_take_idle, clk, rst_n, !busy_reg, !take)
    `Q4_ASSERT_NXT(a_last_frees, clk, rst_n, take && left_reg == 6'd1 && !load, !busy_reg)
endmodule
